>>> rtl/lis_pkg.sv
// Shared constants and types for the longest increasing subsequence block.
// No dependencies; imported by longest_increasing_subsequence.
package lis_pkg;

  // capacity of the value and length stores
  localparam int MAX_ITEMS = 64;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int DATA_W    = 32;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_BACK,
    ST_EMIT
  } state_t;

endpackage

>>> rtl/longest_increasing_subsequence.sv
// Longest strictly increasing subsequence, quadratic DP with one comparator. Uses lis_pkg.
// A stored value holds the block (in_ready low) while it is compared with each earlier value
// through the single registered store port, one compare per earlier value, and then
// written. A final item then adds a backtrack walk and the emit of the picked values.
// Throughput: no new item until the stored one is written; a dropped one per cycle; idle = ready.
// Reset (rst, synchronous): counts, best length and index clear; stores are not cleared.
module longest_increasing_subsequence (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [lis_pkg::DATA_W-1:0] value,
  input  logic                              final_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [lis_pkg::DATA_W-1:0] elem,
  output logic        [lis_pkg::CNT_W-1:0]  seq_len,
  output logic                              run_end
);
  import lis_pkg::*;

  // stores
  logic signed [DATA_W-1:0] value_store  [MAX_ITEMS];
  logic        [CNT_W-1:0]  length_store [MAX_ITEMS];
  logic signed [DATA_W-1:0] pick_stack   [MAX_ITEMS];

  // control registers
  state_t             state, state_next;
  logic [CNT_W-1:0]   item_count, item_count_next;
  logic [CNT_W-1:0]   best_length, best_length_next;
  logic [IDX_W-1:0]   best_index, best_index_next;
  logic [CNT_W-1:0]   pos, pos_next;
  logic [CNT_W-1:0]   cur_len, cur_len_next;
  logic [CNT_W-1:0]   scan_idx, scan_idx_next;
  logic               pend, pend_next;
  logic [IDX_W-1:0]   bk_idx, bk_idx_next;
  logic               bk_live, bk_live_next;
  logic               bk_pend, bk_pend_next;
  logic [CNT_W-1:0]   want, want_next;
  logic [CNT_W-1:0]   depth, depth_next;
  logic [IDX_W-1:0]   top, top_next;
  logic               out_valid_next;

  // payload registers
  logic signed [DATA_W-1:0] v_q, v_next;
  logic                     fin_q, fin_next;
  logic signed [DATA_W-1:0] rd_val;
  logic        [CNT_W-1:0]  rd_len;
  logic        [CNT_W-1:0]  seq_len_next;
  logic                     run_end_next;

  // datapath strobes
  logic             push;
  logic             load;
  logic [IDX_W-1:0] rd_addr;
  logic [CNT_W-1:0] rd_len_inc;
  logic [CNT_W-1:0] nb_len;
  logic [IDX_W-1:0] nb_idx;

  assign in_ready   = (state == ST_IDLE);
  assign rd_addr    = (state == ST_BACK) ? bk_idx : scan_idx[IDX_W-1:0];
  assign rd_len_inc = CNT_W'(rd_len + 1'b1);

  // best so far including the value being written
  always_comb begin
    if (best_length < cur_len) begin
      nb_len = cur_len;
      nb_idx = pos[IDX_W-1:0];
    end else begin
      nb_len = best_length;
      nb_idx = best_index;
    end
  end

  // sequencer: next state and next register values
  always_comb begin
    state_next       = state;
    item_count_next  = item_count;
    best_length_next = best_length;
    best_index_next  = best_index;
    pos_next         = pos;
    cur_len_next     = cur_len;
    scan_idx_next    = scan_idx;
    pend_next        = 1'b0;
    bk_idx_next      = bk_idx;
    bk_live_next     = bk_live;
    bk_pend_next     = 1'b0;
    want_next        = want;
    depth_next       = depth;
    top_next         = top;
    v_next           = v_q;
    fin_next         = fin_q;
    seq_len_next     = seq_len;
    run_end_next     = run_end;
    out_valid_next   = out_valid && !out_ready;
    push             = 1'b0;
    load             = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          v_next   = value;
          fin_next = final_item;
          if (item_count < CNT_W'(MAX_ITEMS)) begin
            pos_next      = item_count;
            cur_len_next  = CNT_W'(1);
            scan_idx_next = '0;
            state_next    = ST_SCAN;
          end else if (final_item) begin
            // store full: item dropped, still emit
            want_next    = best_length;
            bk_idx_next  = best_index;
            bk_live_next = 1'b1;
            depth_next   = '0;
            state_next   = ST_BACK;
          end
        end
      end

      ST_SCAN: begin
        // issue one read per cycle, compare the one issued last cycle
        if (scan_idx < pos) begin
          scan_idx_next = CNT_W'(scan_idx + 1'b1);
          pend_next     = 1'b1;
        end
        if (pend && (v_q > rd_val) && (rd_len_inc > cur_len)) begin
          cur_len_next = rd_len_inc;
        end
        if ((scan_idx == pos) && !pend) begin
          state_next = ST_WRITE;
        end
      end

      ST_WRITE: begin
        best_length_next = nb_len;
        best_index_next  = nb_idx;
        item_count_next  = CNT_W'(pos + 1'b1);
        if (fin_q) begin
          want_next    = nb_len;
          bk_idx_next  = nb_idx;
          bk_live_next = 1'b1;
          depth_next   = '0;
          state_next   = ST_BACK;
        end else begin
          state_next = ST_IDLE;
        end
      end

      ST_BACK: begin
        // walk down from best index, picking each length in turn
        if (bk_live && (want != '0)) begin
          bk_pend_next = 1'b1;
          if (bk_idx == '0) begin
            bk_live_next = 1'b0;
          end else begin
            bk_idx_next = IDX_W'(bk_idx - 1'b1);
          end
        end
        if (bk_pend && (want != '0) && (rd_len == want)) begin
          push       = 1'b1;
          want_next  = CNT_W'(want - 1'b1);
          depth_next = CNT_W'(depth + 1'b1);
        end
        if ((!bk_live || (want == '0)) && !bk_pend) begin
          if (depth != '0) begin
            top_next   = IDX_W'(depth - 1'b1);
            state_next = ST_EMIT;
          end else begin
            item_count_next  = '0;
            best_length_next = '0;
            best_index_next  = '0;
            state_next       = ST_IDLE;
          end
        end
      end

      ST_EMIT: begin
        // pop the stack into the output register when it is free
        if (!out_valid || out_ready) begin
          load           = 1'b1;
          out_valid_next = 1'b1;
          seq_len_next   = best_length;
          run_end_next   = (top == '0);
          if (top == '0) begin
            item_count_next  = '0;
            best_length_next = '0;
            best_index_next  = '0;
            state_next       = ST_IDLE;
          end else begin
            top_next = IDX_W'(top - 1'b1);
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      item_count  <= '0;
      best_length <= '0;
      best_index  <= '0;
      pend        <= 1'b0;
      bk_live     <= 1'b0;
      bk_pend     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      item_count  <= item_count_next;
      best_length <= best_length_next;
      best_index  <= best_index_next;
      pend        <= pend_next;
      bk_live     <= bk_live_next;
      bk_pend     <= bk_pend_next;
      out_valid   <= out_valid_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    pos      <= pos_next;
    cur_len  <= cur_len_next;
    scan_idx <= scan_idx_next;
    bk_idx   <= bk_idx_next;
    want     <= want_next;
    depth    <= depth_next;
    top      <= top_next;
    v_q      <= v_next;
    fin_q    <= fin_next;
    seq_len  <= seq_len_next;
    run_end  <= run_end_next;
  end

  // value and length stores: one write, one registered read
  always_ff @(posedge clk) begin
    if (state == ST_WRITE) begin
      value_store[pos[IDX_W-1:0]]  <= v_q;
      length_store[pos[IDX_W-1:0]] <= cur_len;
    end
    rd_val <= value_store[rd_addr];
    rd_len <= length_store[rd_addr];
  end

  // pick stack: pushed during backtrack, read straight into elem
  always_ff @(posedge clk) begin
    if (push) begin
      pick_stack[depth[IDX_W-1:0]] <= rd_val;
    end
    if (load) begin
      elem <= pick_stack[top];
    end
  end

  // checks
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    item_count <= CNT_W'(MAX_ITEMS))
    else $error("item count above capacity");

  a_best_le_count: assert property (@(posedge clk) disable iff (rst)
    best_length <= item_count)
    else $error("best length exceeds stored items");

  a_emit_depth: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (depth == best_length))
    else $error("backtrack picked wrong number of values");

  a_write_after_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |-> ((scan_idx == pos) && !pend))
    else $error("write before scan completed");

endmodule

>>> verif/longest_increasing_subsequence_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for longest_increasing_subsequence: streams signed
// sequences through valid/ready and checks every emitted subsequence element.
// Depends on lis_pkg and the longest_increasing_subsequence RTL.

typedef struct {
  logic signed [lis_pkg::DATA_W-1:0] elem;
  logic        [lis_pkg::CNT_W-1:0]  seq_len;
  logic                              run_end;
} lis_pick_t;

// Tracks the stored sequence and holds the subsequence elements still owed
class lis_scoreboard;
  logic signed [lis_pkg::DATA_W-1:0] seen_vals [lis_pkg::MAX_ITEMS];
  int unsigned                       run_lens  [lis_pkg::MAX_ITEMS];
  int unsigned                       stored;
  int unsigned                       best_len;
  int unsigned                       best_pos;
  lis_pick_t                         owed [$];
  int                                errors;

  function new();
    stored   = 0;
    best_len = 0;
    best_pos = 0;
    errors   = 0;
  endfunction

  function bit all_done();
    return owed.size() == 0;
  endfunction

  // Update the DP state for one accepted value; on the final one, backtrack
  function void note_input(logic signed [lis_pkg::DATA_W-1:0] v, logic fin);
    int unsigned len;
    int unsigned want;
    int          j;
    lis_pick_t   p;
    logic signed [lis_pkg::DATA_W-1:0] chain [$];
    if (stored < lis_pkg::MAX_ITEMS) begin
      len = 1;
      for (j = 0; j < int'(stored); j++)
        if (v > seen_vals[j] && run_lens[j] + 1 > len)
          len = run_lens[j] + 1;
      seen_vals[stored] = v;
      run_lens[stored]  = len;
      if (best_len < len) begin
        best_len = len;
        best_pos = stored;
      end
      stored++;
    end
    if (!fin)
      return;
    want = best_len;
    for (j = int'(best_pos); j >= 0 && want > 0; j--) begin
      if (run_lens[j] == want) begin
        chain.push_front(seen_vals[j]);
        want--;
      end
    end
    foreach (chain[k]) begin
      p.elem    = chain[k];
      p.seq_len = best_len[lis_pkg::CNT_W-1:0];
      p.run_end = (k == chain.size() - 1);
      owed.insert(owed.size(), p);
    end
    stored   = 0;
    best_len = 0;
    best_pos = 0;
  endfunction

  // Compare one output transfer with the oldest owed element
  function void check_result(logic signed [lis_pkg::DATA_W-1:0] e,
                             logic [lis_pkg::CNT_W-1:0] l, logic r);
    lis_pick_t p;
    if (owed.size() == 0) begin
      $error("unexpected result: elem %0d seq_len %0d run_end %0b", e, l, r);
      errors++;
      return;
    end
    p = owed.pop_front();
    if (e !== p.elem) begin
      $error("elem: expected %0d, actual %0d", p.elem, e);
      errors++;
    end
    if (l !== p.seq_len) begin
      $error("seq_len: expected %0d, actual %0d", p.seq_len, l);
      errors++;
    end
    if (r !== p.run_end) begin
      $error("run_end: expected %0b, actual %0b", p.run_end, r);
      errors++;
    end
  endfunction
endclass

module longest_increasing_subsequence_tb;
  import lis_pkg::*;

  localparam int ITEM_TARGET = 330;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 150;

  typedef enum int {VAL_WIDE, VAL_NARROW, VAL_RISING} val_mode_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [DATA_W-1:0] value;
  logic                     final_item;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] elem;
  logic        [CNT_W-1:0]  seq_len;
  logic                     run_end;

  lis_scoreboard            sb;
  int                       send_idle_pct;
  int                       recv_idle_pct;
  int                       items_sent;
  bit                       hold_req = 1'b0;
  int                       cycles = 0;
  logic signed [DATA_W-1:0] pattern [$];

  longest_increasing_subsequence dut (.*);

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one value; valid stays high across back-to-back transfers
  task automatic send_item(input logic signed [DATA_W-1:0] v, input logic fin);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 20)
      gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    value      <= v;
    final_item <= fin;
    do @(posedge clk); while (!in_ready);
    sb.note_input(v, fin);
    items_sent++;
  endtask

  task automatic send_list();
    foreach (pattern[i])
      send_item(pattern[i], i == pattern.size() - 1);
  endtask

  // One sequence of n values, the last marked final
  task automatic send_run(input int n, input val_mode_t mode);
    logic signed [DATA_W-1:0] v;
    int i;
    v = $urandom;
    for (i = 0; i < n; i++) begin
      case (mode)
        VAL_WIDE:   v = $urandom;
        VAL_NARROW: v = $signed($urandom_range(16)) - 8;
        VAL_RISING: begin
          if (i > 0)
            v = v + $signed($urandom_range(12)) - 3;
        end
        default:    v = 0;
      endcase
      send_item(v, i == n - 1);
    end
  endtask

  // Stop offering and wait for every owed element to leave
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (!sb.all_done());
  endtask

  // Receiver: check transfers, stall at random, honour a long hold-off
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        sb.check_result(elem, seq_len, run_end);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Stimulus
  initial begin
    int run_idx;
    int n;
    int phase;
    int cur_phase;
    sb            = new();
    rst           = 1'b1;
    in_valid      = 1'b0;
    value         = '0;
    final_item    = 1'b0;
    items_sent    = 0;
    send_idle_pct = 27;
    recv_idle_pct = 47;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // single-item runs at both extremes
    send_item(32'sh8000_0000, 1'b1);
    send_item(32'sh7fff_ffff, 1'b1);
    // extremes mixed: the chain runs from the minimum up to the maximum
    pattern = '{32'sh7fff_ffff, 32'sh8000_0000, -32'sd1, 32'sd0, 32'sd1, 32'sh7fff_ffff};
    send_list();
    // equal values are not strictly increasing
    pattern = '{32'sd7, 32'sd7, 32'sd7};
    send_list();
    // falling run: first index wins
    pattern = '{32'sd5, 32'sd3, 32'sd1, -32'sd2};
    send_list();
    pattern = '{32'sd3, 32'sd1, 32'sd4, 32'sd1, 32'sd5, 32'sd9, 32'sd2, 32'sd6};
    send_list();

    // random runs; run 2 overflows capacity, run 6 fills it exactly
    run_idx   = 0;
    cur_phase = 0;
    while (items_sent < ITEM_TARGET) begin
      phase = items_sent * 3 / ITEM_TARGET;
      if (phase != cur_phase) begin
        drain();
        cur_phase     = phase;
        send_idle_pct = (phase == 1) ? 47 : 0;
        recv_idle_pct = (phase == 1) ? 27 : 0;
      end
      if (run_idx == 2)
        n = MAX_ITEMS + $urandom_range(2, 6);
      else if (run_idx == 6)
        n = MAX_ITEMS;
      else if (run_idx == 4)
        n = 5;
      else
        n = $urandom_range(1, 10);
      // long receiver stall while this run and the next are offered
      if (run_idx == 4)
        hold_req = 1'b1;
      send_run(n, val_mode_t'($urandom_range(2)));
      run_idx++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
